### rtl/drs_pkg.sv
// Shared types, codes and defaults for the disk request scheduler.
// No dependencies; imported by drs_front, drs_search, drs_engine and the top level.
package drs_pkg;

    localparam int TRACK_LIMIT_DEF = 1024;
    localparam int QUEUE_DEPTH_DEF = 1024;
    localparam int TRACK_W         = 10;
    localparam int COUNT_W         = 11;
    localparam int CMD_W           = 3;
    localparam int STATUS_W        = 2;
    localparam int GROUP_W         = 32;

    localparam logic [CMD_W-1:0] CMD_REQUEST = 3'd0;
    localparam logic [CMD_W-1:0] CMD_FCFS    = 3'd1;
    localparam logic [CMD_W-1:0] CMD_SSTF    = 3'd2;
    localparam logic [CMD_W-1:0] CMD_LOOK    = 3'd3;
    localparam logic [CMD_W-1:0] CMD_CLOOK   = 3'd4;

    localparam logic [STATUS_W-1:0] ST_SERVED   = 2'd0;
    localparam logic [STATUS_W-1:0] ST_ACCEPTED = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NONE     = 2'd2;
    localparam logic [STATUS_W-1:0] ST_REJECTED = 2'd3;

    localparam logic REG_TRACK_COUNT = 1'b0;
    localparam logic REG_START_POS   = 1'b1;

    typedef enum logic [2:0] {
        OP_REQ,
        OP_FCFS,
        OP_SSTF,
        OP_LOOK,
        OP_CLOOK,
        OP_BAD
    } op_t;

    typedef struct packed {
        op_t                op;
        logic [TRACK_W-1:0] track;
    } cmd_t;

    typedef struct packed {
        logic [TRACK_W-1:0]  served;
        logic [STATUS_W-1:0] status;
    } result_t;

    typedef struct packed {
        logic start;
        logic below;
    } srch_req_t;

    typedef struct packed {
        logic done;
        logic found;
    } srch_rsp_t;

endpackage

### rtl/drs_ram.sv
// Generic simple dual-port RAM, one write port and one registered read port.
// No dependencies.
module drs_ram #(
    parameter int WIDTH = 10,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### rtl/drs_fifo.sv
// Two-entry queue of opaque words, used between the parts of the scheduler.
// No dependencies.
module drs_fifo #(
    parameter int WIDTH = 8
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] din,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] dout,
    output logic             empty
);

    logic [WIDTH-1:0] mem_reg [2];
    logic             wptr_reg;
    logic             rptr_reg;
    logic [1:0]       cnt_reg;
    logic             do_push;
    logic             do_pop;

    assign full    = (cnt_reg == 2'd2);
    assign empty   = (cnt_reg == 2'd0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign dout    = mem_reg[rptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wptr_reg] <= din;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= 1'b0;
            rptr_reg <= 1'b0;
            cnt_reg  <= 2'd0;
        end
        else
        begin
            if (do_push)
            begin
                wptr_reg <= !wptr_reg;
            end
            if (do_pop)
            begin
                rptr_reg <= !rptr_reg;
            end
            if (do_push && !do_pop)
            begin
                cnt_reg <= cnt_reg + 2'd1;
            end
            else if (do_pop && !do_push)
            begin
                cnt_reg <= cnt_reg - 2'd1;
            end
        end
    end

endmodule

### rtl/drs_front.sv
// Front end: accepts commands, decodes them to operations and queues them.
// Depends on drs_pkg and drs_fifo.
module drs_front
    import drs_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    output logic               full,
    input  logic [CMD_W-1:0]   command,
    input  logic [TRACK_W-1:0] track_number,
    output cmd_t               cmd,
    output logic               cmd_valid,
    input  logic               cmd_pop
);

    cmd_t                decoded;
    logic [$bits(cmd_t)-1:0] q_dout;
    logic                q_empty;

    always_comb
    begin
        decoded.track = track_number;
        case (command)
            CMD_REQUEST: decoded.op = OP_REQ;
            CMD_FCFS:    decoded.op = OP_FCFS;
            CMD_SSTF:    decoded.op = OP_SSTF;
            CMD_LOOK:    decoded.op = OP_LOOK;
            CMD_CLOOK:   decoded.op = OP_CLOOK;
            default:     decoded.op = OP_BAD;
        endcase
    end

    drs_fifo #(
        .WIDTH($bits(cmd_t))
    ) u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .din   (decoded),
        .full  (full),
        .pop   (cmd_pop),
        .dout  (q_dout),
        .empty (q_empty)
    );

    assign cmd       = cmd_t'(q_dout);
    assign cmd_valid = !q_empty;

endmodule

### rtl/drs_search.sv
// Two-level priority search over the pending map: nearest set bit at or
// below, or at or above, a position. Depends on drs_pkg.
module drs_search
    import drs_pkg::*;
#(
    parameter int TRACK_LIMIT = TRACK_LIMIT_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic [TRACK_LIMIT-1:0]         map,
    input  srch_req_t                      req,
    input  logic [$clog2(TRACK_LIMIT)-1:0] pos,
    output srch_rsp_t                      rsp,
    output logic [$clog2(TRACK_LIMIT)-1:0] track
);

    localparam int TW = $clog2(TRACK_LIMIT);
    localparam int NW = (TRACK_LIMIT + GROUP_W - 1) / GROUP_W;
    localparam int WW = (NW > 1) ? $clog2(NW) : 1;
    localparam int PW = NW * GROUP_W;
    localparam int BW = $clog2(GROUP_W);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_GROUP,
        S_WORD
    } state_t;

    state_t               state_reg;
    logic                 below_reg;
    logic [WW-1:0]        grp_reg;
    logic [BW-1:0]        bit_reg;
    logic [GROUP_W-1:0]   word_reg;
    logic [NW-1:0]        sum_reg;
    logic                 done_reg;
    logic                 found_reg;
    logic [TW-1:0]        track_reg;

    logic [PW-1:0]        padded;
    logic [GROUP_W-1:0]   words [NW];
    logic [NW-1:0]        sums;
    logic [GROUP_W-1:0]   cur_word;
    logic [GROUP_W-1:0]   bit_mask;
    logic [NW-1:0]        grp_mask;
    logic [BW-1:0]        enc_reg_word;
    logic [BW-1:0]        enc_cur_word;
    logic [WW-1:0]        enc_sum;
    logic [WW+BW-1:0]     pos_ext;

    assign padded  = PW'(map);
    assign pos_ext = (WW + BW)'(pos);

    always_comb
    begin
        for (int i = 0; i < NW; i++)
        begin
            words[i] = padded[i*GROUP_W +: GROUP_W];
            sums[i]  = |words[i];
        end
        cur_word = words[grp_reg];
    end

    always_comb
    begin
        if (below_reg)
        begin
            bit_mask = {GROUP_W{1'b1}} >> (BW'(GROUP_W - 1) - bit_reg);
        end
        else
        begin
            bit_mask = {GROUP_W{1'b1}} << bit_reg;
        end
        for (int i = 0; i < NW; i++)
        begin
            grp_mask[i] = below_reg ? (WW'(i) < grp_reg) : (WW'(i) > grp_reg);
        end
    end

    always_comb
    begin
        enc_reg_word = '0;
        enc_cur_word = '0;
        enc_sum      = '0;
        if (below_reg)
        begin
            for (int i = 0; i < GROUP_W; i++)
            begin
                if (word_reg[i])
                begin
                    enc_reg_word = BW'(i);
                end
                if (cur_word[i])
                begin
                    enc_cur_word = BW'(i);
                end
            end
            for (int i = 0; i < NW; i++)
            begin
                if (sum_reg[i])
                begin
                    enc_sum = WW'(i);
                end
            end
        end
        else
        begin
            for (int i = GROUP_W - 1; i >= 0; i--)
            begin
                if (word_reg[i])
                begin
                    enc_reg_word = BW'(i);
                end
                if (cur_word[i])
                begin
                    enc_cur_word = BW'(i);
                end
            end
            for (int i = NW - 1; i >= 0; i--)
            begin
                if (sum_reg[i])
                begin
                    enc_sum = WW'(i);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            done_reg  <= 1'b0;
            found_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    if (req.start)
                    begin
                        below_reg <= req.below;
                        grp_reg   <= pos_ext[WW+BW-1:BW];
                        bit_reg   <= pos_ext[BW-1:0];
                        state_reg <= S_SCAN;
                    end
                end
                S_SCAN:
                begin
                    word_reg  <= cur_word & bit_mask;
                    sum_reg   <= sums & grp_mask;
                    state_reg <= S_GROUP;
                end
                S_GROUP:
                begin
                    if (word_reg != '0)
                    begin
                        track_reg <= TW'({grp_reg, enc_reg_word});
                        found_reg <= 1'b1;
                        done_reg  <= 1'b1;
                        state_reg <= S_IDLE;
                    end
                    else if (sum_reg != '0)
                    begin
                        grp_reg   <= enc_sum;
                        state_reg <= S_WORD;
                    end
                    else
                    begin
                        track_reg <= '0;
                        found_reg <= 1'b0;
                        done_reg  <= 1'b1;
                        state_reg <= S_IDLE;
                    end
                end
                S_WORD:
                begin
                    track_reg <= TW'({grp_reg, enc_cur_word});
                    found_reg <= 1'b1;
                    done_reg  <= 1'b1;
                    state_reg <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign rsp.done  = done_reg;
    assign rsp.found = found_reg;
    assign track     = track_reg;

endmodule

### rtl/drs_engine.sv
// Back end: holds the pending map, arrival queue, head and sweep state and
// carries out one command at a time. Depends on drs_pkg, drs_ram, drs_search.
module drs_engine
    import drs_pkg::*;
#(
    parameter int TRACK_LIMIT = TRACK_LIMIT_DEF,
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  cmd_t               cmd,
    input  logic               cmd_valid,
    output logic               cmd_pop,
    output result_t            res,
    output logic               res_push,
    input  logic               res_full,
    input  logic               cfg_we,
    input  logic               cfg_index,
    input  logic [COUNT_W-1:0] cfg_data
);

    localparam int TW = $clog2(TRACK_LIMIT);
    localparam int QW = $clog2(QUEUE_DEPTH);

    typedef enum logic [3:0] {
        E_IDLE,
        E_EXEC,
        E_FRD,
        E_FCHK,
        E_WLO,
        E_WHI,
        E_WWRAP,
        E_EMIT
    } state_t;

    state_t                 state_reg, state_next;
    op_t                    op_reg, op_next;
    logic [TRACK_W-1:0]     trk_reg, trk_next;
    logic [TW-1:0]          head_reg, head_next;
    logic                   sweep_down_reg, sweep_down_next;
    logic [COUNT_W-1:0]     tcount_reg, tcount_next;
    logic [TRACK_LIMIT-1:0] map_reg, map_next;
    logic [QW-1:0]          rptr_reg, rptr_next;
    logic [QW-1:0]          wptr_reg, wptr_next;
    logic [QW:0]            fill_reg, fill_next;
    logic [TW-1:0]          lo_reg, lo_next;
    logic                   has_lo_reg, has_lo_next;
    result_t                res_reg, res_next;

    logic                   ram_we;
    logic [TW-1:0]          ram_rdata;
    srch_req_t              srch_req;
    srch_rsp_t              srch_rsp;
    logic [TW-1:0]          srch_pos;
    logic [TW-1:0]          srch_track;
    logic [TW-1:0]          trk_idx;
    logic [TW-1:0]          serve_trk;
    logic                   serve;
    logic [31:0]            limit;
    logic [TW-1:0]          start_clamped;
    logic                   any_pending;

    assign trk_idx     = TW'(trk_reg);
    assign any_pending = |map_reg;
    assign limit       = (32'(tcount_reg) < 32'(TRACK_LIMIT)) ?
                         32'(tcount_reg) : 32'(TRACK_LIMIT);
    assign start_clamped = (32'(cfg_data[TRACK_W-1:0]) >= 32'(TRACK_LIMIT)) ?
                           TW'(TRACK_LIMIT - 1) : TW'(cfg_data[TRACK_W-1:0]);

    drs_ram #(
        .WIDTH(TW),
        .DEPTH(QUEUE_DEPTH)
    ) u_arrival (
        .clk   (clk),
        .we    (ram_we),
        .waddr (wptr_reg),
        .wdata (trk_idx),
        .raddr (rptr_reg),
        .rdata (ram_rdata)
    );

    drs_search #(
        .TRACK_LIMIT(TRACK_LIMIT)
    ) u_search (
        .clk   (clk),
        .rst_n (rst_n),
        .map   (map_reg),
        .req   (srch_req),
        .pos   (srch_pos),
        .rsp   (srch_rsp),
        .track (srch_track)
    );

    always_comb
    begin
        state_next      = state_reg;
        op_next         = op_reg;
        trk_next        = trk_reg;
        head_next       = head_reg;
        sweep_down_next = sweep_down_reg;
        tcount_next     = tcount_reg;
        map_next        = map_reg;
        rptr_next       = rptr_reg;
        wptr_next       = wptr_reg;
        fill_next       = fill_reg;
        lo_next         = lo_reg;
        has_lo_next     = has_lo_reg;
        res_next        = res_reg;
        cmd_pop         = 1'b0;
        res_push        = 1'b0;
        ram_we          = 1'b0;
        srch_req.start  = 1'b0;
        srch_req.below  = 1'b1;
        srch_pos        = head_reg;
        serve           = 1'b0;
        serve_trk       = '0;

        case (state_reg)
            E_IDLE:
            begin
                if (cmd_valid)
                begin
                    cmd_pop    = 1'b1;
                    op_next    = cmd.op;
                    trk_next   = cmd.track;
                    state_next = E_EXEC;
                end
            end
            E_EXEC:
            begin
                res_next.served = '0;
                state_next      = E_EMIT;
                case (op_reg)
                    OP_REQ:
                    begin
                        if (32'(trk_reg) >= limit)
                        begin
                            res_next.status = ST_REJECTED;
                        end
                        else if (map_reg[trk_idx])
                        begin
                            res_next.status = ST_ACCEPTED;
                        end
                        else if (fill_reg == (QW+1)'(QUEUE_DEPTH))
                        begin
                            res_next.status = ST_REJECTED;
                        end
                        else
                        begin
                            map_next[trk_idx] = 1'b1;
                            ram_we            = 1'b1;
                            wptr_next         = (wptr_reg == QW'(QUEUE_DEPTH - 1)) ?
                                                '0 : wptr_reg + 1'b1;
                            fill_next         = fill_reg + 1'b1;
                            res_next.status   = ST_ACCEPTED;
                        end
                    end
                    OP_BAD:
                    begin
                        res_next.status = ST_REJECTED;
                    end
                    default:
                    begin
                        res_next.status = ST_NONE;
                        if (any_pending)
                        begin
                            if (op_reg == OP_FCFS)
                            begin
                                state_next = E_FRD;
                            end
                            else
                            begin
                                srch_req.start = 1'b1;
                                state_next     = E_WLO;
                            end
                        end
                    end
                endcase
            end
            E_FRD:
            begin
                if (fill_reg == '0)
                begin
                    state_next = E_EMIT;
                end
                else
                begin
                    rptr_next  = (rptr_reg == QW'(QUEUE_DEPTH - 1)) ?
                                 '0 : rptr_reg + 1'b1;
                    fill_next  = fill_reg - 1'b1;
                    state_next = E_FCHK;
                end
            end
            E_FCHK:
            begin
                if (map_reg[ram_rdata])
                begin
                    serve     = 1'b1;
                    serve_trk = ram_rdata;
                end
                else
                begin
                    state_next = E_FRD;
                end
            end
            E_WLO:
            begin
                if (srch_rsp.done)
                begin
                    lo_next     = srch_track;
                    has_lo_next = srch_rsp.found;
                    if (op_reg == OP_CLOOK)
                    begin
                        if (srch_rsp.found)
                        begin
                            serve     = 1'b1;
                            serve_trk = srch_track;
                        end
                        else
                        begin
                            srch_req.start = 1'b1;
                            srch_pos       = TW'(TRACK_LIMIT - 1);
                            state_next     = E_WWRAP;
                        end
                    end
                    else
                    begin
                        srch_req.start = 1'b1;
                        srch_req.below = 1'b0;
                        state_next     = E_WHI;
                    end
                end
            end
            E_WWRAP:
            begin
                if (srch_rsp.done)
                begin
                    serve     = 1'b1;
                    serve_trk = srch_track;
                end
            end
            E_WHI:
            begin
                if (srch_rsp.done)
                begin
                    serve = 1'b1;
                    if (!has_lo_reg)
                    begin
                        serve_trk = srch_track;
                        if (op_reg == OP_LOOK)
                        begin
                            sweep_down_next = 1'b0;
                        end
                    end
                    else if (!srch_rsp.found)
                    begin
                        serve_trk = lo_reg;
                        if (op_reg == OP_LOOK)
                        begin
                            sweep_down_next = 1'b1;
                        end
                    end
                    else if (op_reg == OP_LOOK)
                    begin
                        serve_trk = sweep_down_reg ? lo_reg : srch_track;
                    end
                    else
                    begin
                        serve_trk = ((srch_track - head_reg) < (head_reg - lo_reg)) ?
                                    srch_track : lo_reg;
                    end
                end
            end
            E_EMIT:
            begin
                if (!res_full)
                begin
                    res_push   = 1'b1;
                    state_next = E_IDLE;
                end
            end
            default:
            begin
                state_next = E_IDLE;
            end
        endcase

        if (serve)
        begin
            map_next[serve_trk] = 1'b0;
            head_next           = serve_trk;
            res_next.served     = TRACK_W'(serve_trk);
            res_next.status     = ST_SERVED;
            state_next          = E_EMIT;
        end

        if (cfg_we)
        begin
            if (cfg_index == REG_TRACK_COUNT)
            begin
                tcount_next = cfg_data;
            end
            else
            begin
                head_next = start_clamped;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= E_IDLE;
            head_reg       <= '0;
            sweep_down_reg <= 1'b1;
            tcount_reg     <= COUNT_W'(1024);
            map_reg        <= '0;
            rptr_reg       <= '0;
            wptr_reg       <= '0;
            fill_reg       <= '0;
            has_lo_reg     <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            head_reg       <= head_next;
            sweep_down_reg <= sweep_down_next;
            tcount_reg     <= tcount_next;
            map_reg        <= map_next;
            rptr_reg       <= rptr_next;
            wptr_reg       <= wptr_next;
            fill_reg       <= fill_next;
            has_lo_reg     <= has_lo_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg  <= op_next;
        trk_reg <= trk_next;
        lo_reg  <= lo_next;
        res_reg <= res_next;
    end

    assign res = res_reg;

endmodule

### rtl/disk_request_scheduler.sv
// Top level of the disk request scheduler: front end, engine, result queue.
// Depends on drs_pkg, drs_front, drs_engine, drs_fifo.
//
//   channel   ports                               transfer when
//   input     push full command track_number      push && !full
//   result    empty pop served_track status       pop && !empty
//   config    cfg_we cfg_index cfg_data           cfg_we
//
// A request, a bad code or a serve with nothing pending passes through take,
// execute and emit. A map search scans the group of the position and checks
// it, then moves to another group when it has to. SSTF and LOOK search twice;
// C-LOOK searches once, or twice when it wraps. FCFS reads and checks one
// arrival-queue entry at a time through the registered read of that memory.
// Reset clears the pending map and queues at once; no sweep is needed.
// Two-entry queues on both sides let input and output stall independently.
module disk_request_scheduler
    import drs_pkg::*;
#(
    parameter int TRACK_LIMIT = TRACK_LIMIT_DEF,
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    output logic                full,
    input  logic [CMD_W-1:0]    command,
    input  logic [TRACK_W-1:0]  track_number,
    output logic                empty,
    input  logic                pop,
    output logic [TRACK_W-1:0]  served_track,
    output logic [STATUS_W-1:0] status,
    input  logic                cfg_we,
    input  logic                cfg_index,
    input  logic [COUNT_W-1:0]  cfg_data
);

    cmd_t                       cmd;
    logic                       cmd_valid;
    logic                       cmd_pop;
    result_t                    res;
    logic                       res_push;
    logic                       res_full;
    logic [$bits(result_t)-1:0] out_word;
    result_t                    out_res;

    drs_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .full         (full),
        .command      (command),
        .track_number (track_number),
        .cmd          (cmd),
        .cmd_valid    (cmd_valid),
        .cmd_pop      (cmd_pop)
    );

    drs_engine #(
        .TRACK_LIMIT(TRACK_LIMIT),
        .QUEUE_DEPTH(QUEUE_DEPTH)
    ) u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .cmd_valid (cmd_valid),
        .cmd_pop   (cmd_pop),
        .res       (res),
        .res_push  (res_push),
        .res_full  (res_full),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    drs_fifo #(
        .WIDTH($bits(result_t))
    ) u_results (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (res_push),
        .din   (res),
        .full  (res_full),
        .pop   (pop),
        .dout  (out_word),
        .empty (empty)
    );

    assign out_res      = result_t'(out_word);
    assign served_track = out_res.served;
    assign status       = out_res.status;

endmodule

### dv/testbench.sv
// Self-checking testbench for disk_request_scheduler: queued stimulus, clocked driver
// and monitor, and an in-bench scheduling predictor for every command.
// Depends on drs_pkg and the disk_request_scheduler RTL.
`timescale 1ns / 1ps

module testbench;
    import drs_pkg::*;

    localparam int TRACKS = TRACK_LIMIT_DEF;
    localparam int DEPTH  = QUEUE_DEPTH_DEF;

    typedef enum logic [1:0] {ITEM_CMD, ITEM_CFG, ITEM_DRAIN} item_kind_t;

    typedef struct {
        item_kind_t          kind;
        logic [CMD_W-1:0]    cmd;
        logic [TRACK_W-1:0]  trk;
        logic                idx;
        logic [COUNT_W-1:0]  data;
    } stim_t;

    logic                clk;
    logic                rst_n;
    logic                push;
    logic                full;
    logic [CMD_W-1:0]    command;
    logic [TRACK_W-1:0]  track_number;
    logic                empty;
    logic                pop;
    logic [TRACK_W-1:0]  served_track;
    logic [STATUS_W-1:0] status;
    logic                cfg_we;
    logic                cfg_index;
    logic [COUNT_W-1:0]  cfg_data;

    disk_request_scheduler uut (
        .clk(clk), .rst_n(rst_n), .push(push), .full(full), .command(command),
        .track_number(track_number), .empty(empty), .pop(pop),
        .served_track(served_track), .status(status),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    // scheduler state mirror
    bit                 track_pending [TRACKS];
    logic [TRACK_W-1:0] arrival_fifo [DEPTH];
    int                 arr_rd, arr_wr, arr_fill, pending_n, track_limit;
    int                 head_pos;
    bit                 sweep_dn;

    stim_t   cmd_queue [$];
    result_t outcome_queue [$];
    int      mismatches;
    int      accepted_n;
    bit      taken;
    bit      hold_rx;
    int      rx_cycle;
    int      burst_left, gap_left, quiet_cycles;

    always
    begin
        clk = 1'b1;
        #1;
        clk = 1'b0;
        #1;
    end

    task automatic schedule_command(input logic [CMD_W-1:0] c, input logic [TRACK_W-1:0] t,
                                    output result_t r);
        int limit, lo, hi, i;
        bit has_lo, has_hi, found;
        int srv;
        srv = 0;
        found = 0;
        limit = (track_limit < TRACKS) ? track_limit : TRACKS;
        if (c == CMD_REQUEST)
        begin
            if (int'(t) >= limit)
                r.status = ST_REJECTED;
            else if (track_pending[t])
                r.status = ST_ACCEPTED;
            else if (arr_fill >= DEPTH)
                r.status = ST_REJECTED;
            else
            begin
                track_pending[t] = 1;
                pending_n++;
                arrival_fifo[arr_wr] = t;
                arr_wr = (arr_wr + 1) % DEPTH;
                arr_fill++;
                r.status = ST_ACCEPTED;
            end
        end
        else if (c > CMD_CLOOK)
            r.status = ST_REJECTED;
        else if (pending_n == 0)
            r.status = ST_NONE;
        else
        begin
            if (c == CMD_FCFS)
            begin
                while (arr_fill > 0 && !found)
                begin
                    i = int'(arrival_fifo[arr_rd]);
                    arr_rd = (arr_rd + 1) % DEPTH;
                    arr_fill--;
                    if (track_pending[i])
                    begin
                        srv = i;
                        found = 1;
                    end
                end
            end
            else
            begin
                has_lo = 0;
                has_hi = 0;
                lo = 0;
                hi = 0;
                for (i = head_pos; i >= 0 && !has_lo; i--)
                    if (track_pending[i])
                    begin
                        lo = i;
                        has_lo = 1;
                    end
                for (i = head_pos; i < TRACKS && !has_hi; i++)
                    if (track_pending[i])
                    begin
                        hi = i;
                        has_hi = 1;
                    end
                found = has_lo || has_hi;
                if (c == CMD_SSTF)
                begin
                    if (!has_lo)
                        srv = hi;
                    else if (!has_hi)
                        srv = lo;
                    else
                        srv = (hi - head_pos < head_pos - lo) ? hi : lo;
                end
                else if (c == CMD_LOOK)
                begin
                    if (!has_lo)
                    begin
                        srv = hi;
                        sweep_dn = 0;
                    end
                    else if (!has_hi)
                    begin
                        srv = lo;
                        sweep_dn = 1;
                    end
                    else
                        srv = sweep_dn ? lo : hi;
                end
                else if (has_lo)
                    srv = lo;
                else
                begin
                    found = 0;
                    for (i = TRACKS - 1; i >= 0 && !found; i--)
                        if (track_pending[i])
                        begin
                            srv = i;
                            found = 1;
                        end
                end
            end
            if (found)
            begin
                track_pending[srv] = 0;
                pending_n--;
                head_pos = srv;
                r.status = ST_SERVED;
            end
            else
            begin
                srv = 0;
                r.status = ST_NONE;
            end
        end
        r.served = TRACK_W'(srv);
    endtask

    // monitor and predictor
    always @(posedge clk)
    begin
        result_t exp_r;
        taken = 0;
        if (rst_n)
        begin
            if (cfg_we)
            begin
                if (cfg_index == REG_TRACK_COUNT)
                    track_limit = int'(cfg_data);
                else
                    head_pos = int'(cfg_data[TRACK_W-1:0]);
            end
            if (push && !full)
            begin
                schedule_command(command, track_number, exp_r);
                outcome_queue.push_back(exp_r);
                accepted_n++;
                taken = 1;
            end
            if (pop && !empty)
            begin
                if (outcome_queue.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected transfer: served_track=%0d status=%0d",
                                 served_track, status);
                end
                else
                begin
                    exp_r = outcome_queue.pop_front();
                    if (served_track !== exp_r.served || status !== exp_r.status)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: expected track=%0d status=%0d, got track=%0d status=%0d",
                                     exp_r.served, exp_r.status, served_track, status);
                    end
                end
            end
        end
    end

    // driver
    always @(negedge clk)
    begin
        logic p, we;
        p = 0;
        we = 0;
        if (rst_n)
        begin
            if (taken)
                void'(cmd_queue.pop_front());
            if (cmd_queue.size() > 0)
            begin
                case (cmd_queue[0].kind)
                    ITEM_DRAIN:
                    begin
                        quiet_cycles = (outcome_queue.size() == 0) ? quiet_cycles + 1 : 0;
                        if (quiet_cycles >= 30)
                        begin
                            quiet_cycles = 0;
                            void'(cmd_queue.pop_front());
                        end
                    end
                    ITEM_CFG:
                    begin
                        we = 1;
                        cfg_index <= cmd_queue[0].idx;
                        cfg_data <= cmd_queue[0].data;
                        void'(cmd_queue.pop_front());
                    end
                    default:
                    begin
                        if (gap_left > 0)
                            gap_left--;
                        else
                        begin
                            p = 1;
                            command <= cmd_queue[0].cmd;
                            track_number <= cmd_queue[0].trk;
                            if (burst_left > 0)
                                burst_left--;
                            else
                            begin
                                burst_left = $urandom_range(0, 40);
                                gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
                            end
                        end
                    end
                endcase
            end
            rx_cycle++;
            if (hold_rx)
                pop <= 0;
            else
                case ((rx_cycle >> 6) % 3)
                    0: pop <= 1;
                    1: pop <= ($urandom_range(0, 1) == 1);
                    default: pop <= ($urandom_range(0, 3) == 0);
                endcase
        end
        push <= p;
        cfg_we <= we;
    end

    task automatic add_cmd(input logic [CMD_W-1:0] c, input int t);
        stim_t s;
        s.kind = ITEM_CMD;
        s.cmd = c;
        s.trk = TRACK_W'(t);
        s.idx = 1'b0;
        s.data = '0;
        cmd_queue.push_back(s);
    endtask

    task automatic add_setup(input int tc, input int sp);
        stim_t s;
        s.kind = ITEM_DRAIN;
        s.cmd = CMD_REQUEST;
        s.trk = '0;
        s.idx = 1'b0;
        s.data = '0;
        cmd_queue.push_back(s);
        s.kind = ITEM_CFG;
        s.idx = REG_TRACK_COUNT;
        s.data = COUNT_W'(tc);
        cmd_queue.push_back(s);
        s.idx = REG_START_POS;
        s.data = COUNT_W'(sp);
        cmd_queue.push_back(s);
    endtask

    initial
    begin
        int tc, n, r, t;
        for (int i = 0; i < TRACKS; i++)
            track_pending[i] = 0;
        arr_rd = 0;
        arr_wr = 0;
        arr_fill = 0;
        pending_n = 0;
        track_limit = TRACKS;
        head_pos = 0;
        sweep_dn = 1;
        mismatches = 0;
        accepted_n = 0;
        hold_rx = 0;
        rx_cycle = 0;
        burst_left = 0;
        gap_left = 0;
        quiet_cycles = 0;
        taken = 0;
        rst_n = 0;
        push = 0;
        pop = 0;
        command = CMD_REQUEST;
        track_number = 0;
        cfg_we = 0;
        cfg_index = REG_TRACK_COUNT;
        cfg_data = 0;

        // directed: empty serves, bad codes, edges, ties, sweep reversal, wrap
        add_cmd(CMD_FCFS, 0);
        add_cmd(CMD_SSTF, 0);
        add_cmd(CMD_LOOK, 0);
        add_cmd(CMD_CLOOK, 0);
        add_cmd(3'd5, 1023);
        add_cmd(3'd7, 0);
        add_setup(1024, 512);
        add_cmd(CMD_REQUEST, 1023);
        add_cmd(CMD_REQUEST, 0);
        add_cmd(CMD_REQUEST, 510);
        add_cmd(CMD_REQUEST, 514);
        add_cmd(CMD_REQUEST, 514);
        add_cmd(CMD_SSTF, 0);
        add_cmd(CMD_LOOK, 0);
        add_cmd(CMD_LOOK, 0);
        add_cmd(CMD_CLOOK, 0);
        add_cmd(CMD_REQUEST, 700);
        add_cmd(CMD_CLOOK, 0);
        add_cmd(CMD_FCFS, 0);
        add_cmd(CMD_FCFS, 0);
        add_setup(1, 1023);
        add_cmd(CMD_REQUEST, 0);
        add_cmd(CMD_REQUEST, 1);
        add_cmd(CMD_REQUEST, 1023);
        add_cmd(CMD_LOOK, 0);
        add_cmd(3'd6, 0);

        // random phases under several settings
        for (int ph = 0; ph < 5; ph++)
        begin
            case (ph)
                0: tc = 1024;
                1: tc = 1;
                2: tc = $urandom_range(2, 64);
                3: tc = 2047;
                default: tc = $urandom_range(65, 1023);
            endcase
            add_setup(tc, (ph == 3) ? 1023 : ((ph == 1) ? 0 : $urandom_range(0, 1023)));
            n = (tc > 1024) ? 1024 : tc;
            for (int k = 0; k < 105; k++)
            begin
                r = $urandom_range(0, 99);
                if (r < 45)
                begin
                    if ($urandom_range(0, 9) == 0)
                        t = $urandom_range(0, 1023);
                    else
                        t = $urandom_range(0, n - 1);
                    add_cmd(CMD_REQUEST, t);
                end
                else if (r < 95)
                    add_cmd(CMD_W'($urandom_range(CMD_FCFS, CMD_CLOOK)),
                            $urandom_range(0, 1023));
                else
                    add_cmd(CMD_W'($urandom_range(5, 7)), $urandom_range(0, 1023));
            end
            if (ph == 2)
                add_setup(tc, 0);
        end

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1;

        while (cmd_queue.size() > 0 || outcome_queue.size() > 0)
            @(posedge clk);
        repeat (60) @(posedge clk);
        if (mismatches == 0 && outcome_queue.size() == 0)
            $display("disk_request_scheduler verification clean");
        else
            $display("disk_request_scheduler verification failed");
        $finish;
    end

    // long receiver hold-off while the sender keeps going
    initial
    begin
        wait (accepted_n >= 300);
        @(posedge clk);
        hold_rx = 1;
        repeat (400) @(posedge clk);
        hold_rx = 0;
    end

    initial
    begin
        #2000000;
        $display("disk_request_scheduler verification failed");
        $finish;
    end

endmodule
